### hdl/biquad_filter_bank_energy_top_defines.svh
// Assertion macros for the filter bank top module.
// No dependencies.
`ifndef BIQUAD_FILTER_BANK_ENERGY_TOP_DEFINES_SVH
`define BIQUAD_FILTER_BANK_ENERGY_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define BFB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication with the consequent checked in the next cycle
`define BFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hdl/bfb_pkg.sv
// Types and constants for the biquad filter bank.
// No dependencies.
package bfb_pkg;
    localparam int SAMPLE_W = 16;
    localparam int SIG_W    = 32;
    localparam int COEF_W   = 32;
    localparam int ENERGY_W = 64;
    localparam int FRAC_W   = 29;
    localparam int ACC_W    = 72;
    localparam int PROD_W   = 64;

    localparam logic [1:0] SEL_B0 = 2'd0;
    localparam logic [1:0] SEL_B1 = 2'd1;
    localparam logic [1:0] SEL_A1 = 2'd2;
    localparam logic [1:0] SEL_A2 = 2'd3;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    typedef logic signed [SIG_W-1:0]  sig_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic       start;
        logic       first;
        logic [1:0] step;
    } cell_ctl_t;

    function automatic sig_t sat_round(input acc_t acc);
        acc_t r;
        acc_t q;
        begin
            r = acc + (acc_t'(1) <<< (FRAC_W - 1));
            q = r >>> FRAC_W;
            if (q > acc_t'(32'sh7FFFFFFF))
                sat_round = sig_t'(32'sh7FFFFFFF);
            else if (q < -acc_t'(64'sh80000000))
                sat_round = sig_t'(32'sh80000000);
            else
                sat_round = q[SIG_W-1:0];
        end
    endfunction
endpackage

### hdl/bfb_cell.sv
// One biquad section cell: history, coefficients and a shared MAC over 4 steps.
// Depends on bfb_pkg.
module bfb_cell #(
    parameter int BANDS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bfb_pkg::cell_ctl_t       ctl,
    input  logic [((BANDS > 1) ? $clog2(BANDS) : 1)-1:0] band,
    input  bfb_pkg::sig_t            u,
    input  logic                     coef_we,
    input  logic [1:0]               coef_sel,
    input  bfb_pkg::coef_t           coef_value,
    output bfb_pkg::sig_t            y
);
    import bfb_pkg::*;

    localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

    sig_t  x0_mem [BANDS];
    sig_t  x1_mem [BANDS];
    sig_t  y0_mem [BANDS];
    sig_t  y1_mem [BANDS];
    coef_t c_mem [BANDS][4];
    acc_t  acc_reg;
    sig_t  y_reg;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] prod_raw;
    logic  neg;
    coef_t cf;
    sig_t  op;
    logic [BW-1:0] bi;
    logic  [BW-1:0] wb_reg;
    logic  wb_valid_reg;
    sig_t  u_reg;

    assign bi = band;
    assign y  = y_reg;

    // feedback terms are negated after the multiply so a -4.0 coefficient stays exact
    always_comb
    begin
        case (ctl.step)
            2'd0:
            begin
                cf  = c_mem[bi][SEL_B1];
                op  = x1_mem[bi];
                neg = 1'b0;
            end
            2'd1:
            begin
                cf  = ctl.first ? c_mem[bi][SEL_B0] : coef_t'(32'sh20000000);
                op  = u;
                neg = 1'b0;
            end
            2'd2:
            begin
                cf  = c_mem[bi][SEL_A1];
                op  = y1_mem[bi];
                neg = 1'b1;
            end
            default:
            begin
                cf  = c_mem[bi][SEL_A2];
                op  = y0_mem[bi];
                neg = 1'b1;
            end
        endcase
        prod_raw = PROD_W'($signed(cf) * $signed(op));
        prod     = neg ? -prod_raw : prod_raw;
    end

    // x0 term shares the u coefficient (b0 in the first section, unity in the others); it is added on the b1 step
    logic signed [PROD_W-1:0] x0_prod;
    acc_t x0_term;
    always_comb
    begin
        x0_prod = PROD_W'($signed(ctl.first ? c_mem[bi][SEL_B0] : coef_t'(32'sh20000000))
                          * $signed(x0_mem[bi]));
        x0_term = acc_t'(x0_prod);
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
            c_mem[bi][coef_sel] <= coef_value;
        if (ctl.start)
            acc_reg <= acc_t'($signed(prod)) + x0_term;
        else
            acc_reg <= acc_reg + acc_t'($signed(prod));
        if (ctl.step == 2'd1)
            u_reg <= u;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
            wb_reg       <= '0;
            y_reg        <= '0;
            for (int i = 0; i < BANDS; i++)
            begin
                x0_mem[i] <= '0;
                x1_mem[i] <= '0;
                y0_mem[i] <= '0;
                y1_mem[i] <= '0;
            end
        end
        else
        begin
            wb_valid_reg <= (ctl.step == 2'd3) && !coef_we && !ctl.start;
            wb_reg       <= bi;
            if (wb_valid_reg)
            begin
                y_reg              <= sat_round(acc_reg);
                x0_mem[wb_reg]     <= x1_mem[wb_reg];
                x1_mem[wb_reg]     <= u_reg;
                y0_mem[wb_reg]     <= y1_mem[wb_reg];
                y1_mem[wb_reg]     <= sat_round(acc_reg);
            end
        end
    end
endmodule

### hdl/biquad_filter_bank_energy_top.sv
// Biquad filter bank with per-band energy: sequencer, section cells, energy and output.
// Depends on bfb_pkg, bfb_cell and the assertion macro header.
//
// Usage:
//   s_axis: tdata = {coef_value, coef_select, coef_section, coef_band,
//           clear_energy, sample_in} (56 bits), tuser = command.
//   m_axis: tdata = {band_energy, band_output} (96 bits), tuser = band_index,
//           tlast = last_band.
//   A coefficient word is written when it is accepted and gives no output.
//   A sample word is run band by band: each band walks the section cells
//   one at a time, each section through 4 MAC steps and two writeback
//   states (ST_WB, ST_WB2), then ST_OUT does the energy update and output.
//   No new word is accepted until the last band of a sample is loaded
//   for output; the shared MAC in each cell serialises the work.
//   Reset clears histories, energies and control; coefficients stay
//   undefined until written.
//   When m_axis stalls, the sequencer holds on the finished band result.
`include "biquad_filter_bank_energy_top_defines.svh"
module biquad_filter_bank_energy_top #(
    parameter int BANDS    = 8,
    parameter int SECTIONS = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sample_in, clear_energy, coef_band, coef_section, coef_select, coef_value
    input  logic [55:0]  s_axis_tdata,
    // command
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // band_output, band_energy
    output logic [95:0]  m_axis_tdata,
    // band_index
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import bfb_pkg::*;

    localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_WB   = 3'd2;
    localparam logic [2:0] ST_WB2  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]    state_reg;
    logic [BW-1:0] band_reg;
    logic [SW-1:0] sec_reg;
    logic [1:0]    step_reg;
    sig_t          sample_reg;
    logic          clear_reg;
    logic [ENERGY_W-1:0] energy_mem [BANDS];
    logic          out_valid_reg;
    logic [95:0]   out_data_reg;
    logic [2:0]    out_band_reg;
    logic          out_last_reg;

    sig_t  cell_y [SECTIONS];
    sig_t  cell_u [SECTIONS];
    logic  in_acc;
    logic  is_coef;
    logic  out_load;
    logic [2:0] c_band;
    logic [1:0] c_sec;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign is_coef = (s_axis_tuser == CMD_COEF);
    assign c_band  = s_axis_tdata[19:17];
    assign c_sec   = s_axis_tdata[21:20];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    for (genvar s = 0; s < SECTIONS; s++)
    begin : g_cell
        cell_ctl_t       ctl;
        logic [BW-1:0]   cb;
        logic            we;
        always_comb
        begin
            ctl.start = (state_reg == ST_MAC) && (sec_reg == SW'(s)) && (step_reg == 2'd0);
            ctl.first = (s == 0);
            ctl.step  = ((state_reg == ST_MAC) && (sec_reg == SW'(s))) ? step_reg : 2'd0;
            we = in_acc && is_coef && (32'(c_band) < BANDS) && (32'(c_sec) == s);
            cb = we ? BW'(c_band) : band_reg;
        end
        if (s == 0)
        begin : g_u0
            assign cell_u[s] = sample_reg;
        end
        else
        begin : g_un
            assign cell_u[s] = cell_y[s-1];
        end
        bfb_cell #(.BANDS(BANDS)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .band       (cb),
            .u          (cell_u[s]),
            .coef_we    (we),
            .coef_sel   (s_axis_tdata[23:22]),
            .coef_value (s_axis_tdata[55:24]),
            .y          (cell_y[s])
        );
    end

    sig_t yl;
    logic signed [63:0] sq;
    logic [ENERGY_W:0] esum;
    logic [ENERGY_W-1:0] eold;
    assign yl   = cell_y[SECTIONS-1];
    assign sq   = 64'($signed(yl) * $signed(yl));
    assign eold = clear_reg ? '0 : energy_mem[band_reg];
    assign esum = {1'b0, eold} + {1'b0, sq};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            band_reg      <= '0;
            sec_reg       <= '0;
            step_reg      <= '0;
            clear_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
            out_data_reg  <= '0;
            out_band_reg  <= '0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < BANDS; i++)
                energy_mem[i] <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && !is_coef)
                    begin
                        sample_reg <= sig_t'($signed(s_axis_tdata[15:0])) <<< 8;
                        clear_reg  <= s_axis_tdata[16];
                        band_reg   <= '0;
                        sec_reg    <= '0;
                        step_reg   <= '0;
                        state_reg  <= ST_MAC;
                    end
                end
                ST_MAC:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                        state_reg <= ST_WB;
                end
                ST_WB:
                    state_reg <= ST_WB2;
                ST_WB2:
                begin
                    if (32'(sec_reg) == SECTIONS - 1)
                        state_reg <= ST_OUT;
                    else
                    begin
                        sec_reg   <= sec_reg + SW'(1);
                        state_reg <= ST_MAC;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        energy_mem[band_reg] <= esum[ENERGY_W] ? '1 : esum[ENERGY_W-1:0];
                        out_data_reg  <= {(esum[ENERGY_W] ? {ENERGY_W{1'b1}} : esum[ENERGY_W-1:0]),
                                          yl};
                        out_band_reg  <= 3'(band_reg);
                        out_last_reg  <= (32'(band_reg) == BANDS - 1);
                        sec_reg       <= '0;
                        if (clear_reg)
                        begin
                            for (int i = 0; i < BANDS; i++)
                                if (i != 32'(band_reg))
                                    energy_mem[i] <= '0;
                            clear_reg <= 1'b0;
                        end
                        if (32'(band_reg) == BANDS - 1)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            band_reg  <= band_reg + BW'(1);
                            state_reg <= ST_MAC;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_band_reg;
    assign m_axis_tlast  = out_last_reg;

    `BFB_ASSERT_IMP(a_busy_not_ready, state_reg != ST_IDLE, !s_axis_tready, "ready while busy")
    `BFB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output dropped")
    `BFB_ASSERT_IMP(a_last_band, m_axis_tvalid && m_axis_tlast, 32'(m_axis_tuser) == BANDS - 1, "bad last")
endmodule

### tb/tb_biquad_filter_bank_energy_top.sv
// Testbench for the biquad filter bank with per-band energy accumulation.
// Needs bfb_pkg and biquad_filter_bank_energy_top; predicts every band result
// from its own filter model and checks each output word against it.
module tb_biquad_filter_bank_energy_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bfb_pkg::*;

    localparam int BANDS    = 8;
    localparam int SECTIONS = 4;
    localparam int WATCHDOG = 20000;

    typedef struct {
        logic [2:0]  band;
        logic [31:0] y;
        logic [63:0] energy;
        logic        last;
    } band_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    biquad_filter_bank_energy_top #(.BANDS(BANDS), .SECTIONS(SECTIONS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // filter model state
    logic signed [31:0] x_hist [BANDS*SECTIONS][2];
    logic signed [31:0] y_hist [BANDS*SECTIONS][2];
    logic signed [31:0] coefs  [BANDS*SECTIONS*4];
    logic [63:0]        energy [BANDS];

    band_result_t band_q[$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_cnt;
    int idle_cycles;
    int samples_sent;
    int coefs_sent;
    int results_seen;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic signed [31:0] run_section(int idx, logic signed [31:0] u,
                                                       bit first);
        logic signed [79:0] acc;
        logic signed [79:0] t;
        logic signed [79:0] q;
        logic signed [31:0] y;
        acc = longint'(coefs[idx*4+SEL_B1]) * longint'(x_hist[idx][1]);
        if (first)
        begin
            acc = acc + longint'(coefs[idx*4+SEL_B0]) * longint'(u);
            acc = acc + longint'(coefs[idx*4+SEL_B0]) * longint'(x_hist[idx][0]);
        end
        else
        begin
            t = longint'(u) + longint'(x_hist[idx][0]);
            acc = acc + (t <<< FRAC_W);
        end
        acc = acc - longint'(coefs[idx*4+SEL_A1]) * longint'(y_hist[idx][1]);
        acc = acc - longint'(coefs[idx*4+SEL_A2]) * longint'(y_hist[idx][0]);
        q = (acc + (80'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
        if (q > 80'sd2147483647)
            y = 32'sh7FFFFFFF;
        else if (q < -80'sd2147483648)
            y = 32'sh80000000;
        else
            y = q[31:0];
        x_hist[idx][0] = x_hist[idx][1];
        x_hist[idx][1] = u;
        y_hist[idx][0] = y_hist[idx][1];
        y_hist[idx][1] = y;
        return y;
    endfunction

    task automatic predict_word(logic cmd, logic [55:0] d);
        logic signed [31:0] sig;
        logic [64:0]        sum;
        longint             sq;
        band_result_t       r;
        if (cmd == CMD_COEF)
        begin
            coefs[(d[19:17]*SECTIONS + d[21:20])*4 + d[23:22]] = d[55:24];
            return;
        end
        if (d[16])
            for (int b = 0; b < BANDS; b++)
                energy[b] = '0;
        for (int b = 0; b < BANDS; b++)
        begin
            sig = 32'(signed'(d[15:0])) <<< 8;
            for (int s = 0; s < SECTIONS; s++)
                sig = run_section(b*SECTIONS + s, sig, s == 0);
            sq = longint'(sig) * longint'(sig);
            sum = {1'b0, energy[b]} + {1'b0, 64'(sq)};
            energy[b] = sum[64] ? '1 : sum[63:0];
            r.band = 3'(b);
            r.y = sig;
            r.energy = energy[b];
            r.last = (b == BANDS - 1);
            band_q.push_back(r);
        end
    endtask

    // entered and left at a falling edge
    task automatic send_word(logic cmd, logic [15:0] smp, logic clr, logic [2:0] band,
                             logic [1:0] sec, logic [1:0] sel, logic [31:0] val);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {val, sel, sec, band, clr, smp};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_word(cmd, s_axis_tdata);
        if (cmd == CMD_COEF)
            coefs_sent++;
        else
            samples_sent++;
        @(negedge clk);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    task automatic send_sample(logic [15:0] smp, logic clr);
        send_word(CMD_SAMPLE, smp, clr, 3'($urandom), 2'($urandom), 2'($urandom), $urandom);
    endtask

    task automatic send_coef(logic [2:0] band, logic [1:0] sec, logic [1:0] sel,
                             logic [31:0] val);
        send_word(CMD_COEF, 16'($urandom), 1'($urandom), band, sec, sel, val);
    endtask

    // mostly well-behaved coefficients; wild ones drive saturation
    function automatic logic [31:0] pick_coef(logic [1:0] sel, bit wild);
        if (wild)
            return $urandom;
        case (sel)
            SEL_B0:  return 32'($urandom_range(0, 32'h20000000)) - 32'h10000000;
            SEL_B1:  return 32'($urandom_range(0, 32'h10000000)) - 32'h08000000;
            SEL_A1:  return 32'($urandom_range(0, 32'h08000000)) - 32'h04000000;
            default: return 32'($urandom_range(0, 32'h04000000)) - 32'h02000000;
        endcase
    endfunction

    task automatic test_load_bank(bit wild);
        for (int b = 0; b < BANDS; b++)
            for (int s = 0; s < SECTIONS; s++)
                for (int c = 0; c < 4; c++)
                    send_coef(3'(b), 2'(s), 2'(c), pick_coef(2'(c), wild));
    endtask

    task automatic test_directed();
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0001, 1'b0);
        // clear flag on a coefficient word has no effect
        send_word(CMD_COEF, 16'h7FFF, 1'b1, 3'd7, 2'd3, SEL_A2, 32'h0000_0000);
        send_sample(16'h1234, 1'b0);
        // gain written to a later section stays unused
        send_coef(3'd2, 2'd2, SEL_B0, 32'h7FFF_FFFF);
        send_coef(3'd0, 2'd0, SEL_B0, 32'h7FFF_FFFF);
        send_coef(3'd0, 2'd0, SEL_B1, 32'h8000_0000);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h4000, 1'b1);
    endtask

    task automatic test_saturation();
        for (int b = 0; b < 2; b++)
        begin
            send_coef(3'(b), 2'd0, SEL_B0, 32'h7FFF_FFFF);
            send_coef(3'(b), 2'd0, SEL_A1, 32'h8000_0000);
        end
        for (int i = 0; i < 4; i++)
            send_sample((i % 2) ? 16'h8000 : 16'h7FFF, i == 0);
    endtask

    task automatic test_random(int count);
        logic [1:0] sel;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 20)
            begin
                sel = 2'($urandom);
                send_coef(3'($urandom), 2'($urandom), sel,
                          pick_coef(sel, $urandom_range(0, 99) < 10));
            end
            else if ($urandom_range(0, 9) == 0)
                send_sample($urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                            $urandom_range(0, 9) == 0);
            else
                send_sample(16'($urandom), $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        for (int i = 0; i < 4; i++)
            send_sample(16'($urandom), 1'b0);
    endtask

    task automatic set_idling(int snd, int rcv);
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
    endtask

    always @(negedge clk)
    begin
        if (hold_req != 0 && hold_cnt == 0)
        begin
            hold_cnt = 1500;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = $urandom_range(0, 99) >= recv_stall_pct;
    end

    always @(posedge clk)
    begin
        band_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (band_q.size() == 0)
            begin
                $error("unexpected band word: band %0d", m_axis_tuser);
                errors++;
            end
            else
            begin
                e = band_q.pop_front();
                if (m_axis_tuser !== e.band)
                begin
                    $error("band_index: expected %0d, got %0d", e.band, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[31:0] !== e.y)
                begin
                    $error("band_output: expected %0h, got %0h", e.y, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[95:32] !== e.energy)
                begin
                    $error("band_energy: expected %0h, got %0h", e.energy,
                           m_axis_tdata[95:32]);
                    errors++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("last_band: expected %0b, got %0b", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG);
            $display("tb_biquad_filter_bank_energy_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        hold_req = 0;
        hold_cnt = 0;
        samples_sent = 0;
        coefs_sent = 0;
        results_seen = 0;
        set_idling(0, 0);
        for (int i = 0; i < BANDS*SECTIONS; i++)
        begin
            x_hist[i][0] = '0;
            x_hist[i][1] = '0;
            y_hist[i][0] = '0;
            y_hist[i][1] = '0;
        end
        for (int i = 0; i < BANDS*SECTIONS*4; i++)
            coefs[i] = '0;
        for (int b = 0; b < BANDS; b++)
            energy[b] = '0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_load_bank(1'b0);
        test_directed();
        set_idling(66, 0);
        test_random(4);
        set_idling(0, 66);
        test_random(4);
        set_idling(16, 16);
        test_random(4);
        set_idling(0, 0);
        test_random(4);
        test_backpressure();
        set_idling(16, 16);
        test_saturation();
        s_axis_tvalid = 1'b0;

        while (band_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d samples and %0d coefficient words, %0d band words checked",
                 samples_sent, coefs_sent, results_seen);
        $display("extremes, clears, saturation, idling phases and a long output stall");
        if (errors == 0)
            $display("tb_biquad_filter_bank_energy_top: PASS");
        else
            $display("tb_biquad_filter_bank_energy_top: FAIL");
        $finish;
    end
endmodule

### filelist.f
+incdir+hdl
hdl/bfb_pkg.sv
hdl/bfb_cell.sv
hdl/biquad_filter_bank_energy_top.sv
tb/tb_biquad_filter_bank_energy_top.sv
